// ===== hw/rtl/bhk_pkg.sv =====
`timescale 1ns / 1ps

package bhk_pkg;

  localparam int HEAP_DEPTH  = 32;
  localparam int VALUE_WIDTH = 64;
  localparam int DATA_W      = 64;
  localparam int KEEP_W      = 6;
  localparam int KEEP_RESET  = 32;
  localparam int ADDR_W      = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CNT_W       = $clog2(HEAP_DEPTH + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  typedef logic [VALUE_WIDTH-1:0] word_t;

  typedef struct packed {
    logic              opcode;
    logic [DATA_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] held_value;
    logic              last;
  } out_req_t;

  typedef struct packed {
    logic     valid;
    out_req_t req;
  } emit_t;

endpackage

// ===== hw/rtl/bhk_engine.sv =====
`timescale 1ns / 1ps

module bhk_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  bhk_pkg::in_req_t           req_i,
  input  logic [bhk_pkg::KEEP_W-1:0] keep_i,
  output logic                       busy_o,
  output bhk_pkg::emit_t             res_o,
  input  logic                       res_ready_i
);
  import bhk_pkg::*;

  localparam int CH_W  = ADDR_W + 2;
  localparam int CMP_W = ((KEEP_W > CNT_W) ? KEEP_W : CNT_W) + 1;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_TOP_CMP = 8'b0000_0010,
    S_SU_RD   = 8'b0000_0100,
    S_SU_CMP  = 8'b0000_1000,
    S_SD_RD   = 8'b0001_0000,
    S_SD_CMP  = 8'b0010_0000,
    S_DR_RD   = 8'b0100_0000,
    S_DR_TAKE = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   held_q, held_d;
  logic [ADDR_W-1:0]  pos_q, pos_d;
  logic [ADDR_W-1:0]  chl_q, chl_d;
  logic               rok_q, rok_d;
  logic               drain_q, drain_d;
  word_t              v_q, v_d;

  word_t              mem [HEAP_DEPTH];
  logic               we;
  logic [ADDR_W-1:0]  wa;
  word_t              wd;
  logic               ra_en, rb_en;
  logic [ADDR_W-1:0]  ra, rb;
  word_t              rdata_a_q, rdata_b_q;

  logic [CMP_W-1:0]   eff_k;
  logic               full;
  logic [CH_W-1:0]    child;
  logic [ADDR_W-1:0]  parent;
  logic               pick_r;
  logic               ch_lt;
  word_t              ch_val;
  state_e             fin_state;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ra_en) begin
      rdata_a_q <= mem[ra];
    end
    if (rb_en) begin
      rdata_b_q <= mem[rb];
    end
  end

  always_comb begin
    if (keep_i == '0) begin
      eff_k = CMP_W'(1);
    end else if (CMP_W'(keep_i) > CMP_W'(HEAP_DEPTH)) begin
      eff_k = CMP_W'(HEAP_DEPTH);
    end else begin
      eff_k = CMP_W'(keep_i);
    end
  end

  assign full   = CMP_W'(held_q) >= eff_k;
  assign child  = {1'b0, pos_q, 1'b0} + CH_W'(1);
  assign parent = ADDR_W'((pos_q - ADDR_W'(1)) >> 1);
  assign pick_r = rok_q && (rdata_a_q < rdata_b_q);
  assign ch_val = pick_r ? rdata_b_q : rdata_a_q;
  assign ch_lt  = pick_r ? (rdata_b_q < v_q) : (rdata_a_q < v_q);
  assign fin_state = (drain_q && held_q != '0) ? S_DR_RD : S_IDLE;
  assign busy_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    held_d  = held_q;
    pos_d   = pos_q;
    chl_d   = chl_q;
    rok_d   = rok_q;
    drain_d = drain_q;
    v_d     = v_q;
    we      = 1'b0;
    wa      = pos_q;
    wd      = v_q;
    ra_en   = 1'b0;
    ra      = '0;
    rb_en   = 1'b0;
    rb      = '0;
    res_o.valid          = 1'b0;
    res_o.req.held_value = DATA_W'(rdata_a_q);
    res_o.req.last       = (held_q == CNT_W'(1));
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          v_d     = req_i.value[VALUE_WIDTH-1:0];
          drain_d = (req_i.opcode == OP_DRAIN);
          if (req_i.opcode == OP_DRAIN) begin
            if (held_q != '0) begin
              ra_en   = 1'b1;
              rb_en   = 1'b1;
              rb      = ADDR_W'(held_q - CNT_W'(1));
              state_d = S_DR_TAKE;
            end
          end else if (full) begin
            ra_en   = 1'b1;
            state_d = S_TOP_CMP;
          end else begin
            pos_d   = ADDR_W'(held_q);
            held_d  = held_q + CNT_W'(1);
            state_d = S_SU_RD;
          end
        end
      end
      S_TOP_CMP: begin
        if (v_q < rdata_a_q) begin
          pos_d   = '0;
          state_d = S_SD_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SU_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_IDLE;
        end else begin
          ra_en   = 1'b1;
          ra      = parent;
          state_d = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        we = 1'b1;
        if (rdata_a_q < v_q) begin
          wd      = rdata_a_q;
          pos_d   = parent;
          state_d = S_SU_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SD_RD: begin
        if (child >= CH_W'(held_q)) begin
          we      = 1'b1;
          state_d = fin_state;
        end else begin
          ra_en   = 1'b1;
          ra      = ADDR_W'(child);
          rb_en   = 1'b1;
          rb      = ADDR_W'(child + CH_W'(1));
          chl_d   = ADDR_W'(child);
          rok_d   = (child + CH_W'(1)) < CH_W'(held_q);
          state_d = S_SD_CMP;
        end
      end
      S_SD_CMP: begin
        we = 1'b1;
        if (ch_lt) begin
          state_d = fin_state;
        end else begin
          wd      = ch_val;
          pos_d   = pick_r ? ADDR_W'(chl_q + ADDR_W'(1)) : chl_q;
          state_d = S_SD_RD;
        end
      end
      S_DR_RD: begin
        ra_en   = 1'b1;
        rb_en   = 1'b1;
        rb      = ADDR_W'(held_q - CNT_W'(1));
        state_d = S_DR_TAKE;
      end
      S_DR_TAKE: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          v_d     = rdata_b_q;
          held_d  = held_q - CNT_W'(1);
          pos_d   = '0;
          state_d = S_SD_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      held_q  <= '0;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      drain_q <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    chl_q <= chl_d;
    rok_q <= rok_d;
    v_q   <= v_d;
  end

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(HEAP_DEPTH))
    else $error("held count above heap depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && ((ra_en && ra == wa) || (rb_en && rb == wa))))
    else $error("read and write to one entry in one cycle");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (held_q != '0 && drain_q))
    else $error("result request outside a drain");

  a_insert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.opcode == OP_INSERT) |=> busy_o)
    else $error("insert request did not start work");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DR_TAKE && res_ready_i && held_q == CNT_W'(1)) |=> ##1 (held_q == '0))
    else $error("drain left values held");

endmodule

// ===== hw/rtl/bounded_heap_k_smallest.sv =====
`timescale 1ns / 1ps
// insert: a new request is taken only once the previous one is done; append path sifts up,
// replace path reads the top, sifts down only if the new value is below it, else drops it;
// per level one parent read (sift up) or two child reads (sift down), and one write-back
// drain: emits each top value, then sifts the last value down; gated by the output register
// the heap memory has two read ports and one write port; stall is high while work is open
// reset: held count cleared, keep_q set to 32, output empty; no memory clearing pass

module bounded_heap_k_smallest (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bhk_pkg::in_req_t           in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bhk_pkg::out_req_t          out_req_o,
  input  logic                       cfg_we_i,
  input  logic [bhk_pkg::KEEP_W-1:0] cfg_wdata_i
);
  import bhk_pkg::*;

  logic [KEEP_W-1:0] keep_q;
  logic              busy;
  logic              res_ready;
  emit_t             res;
  logic              out_valid_q;
  out_req_t          out_req_q;

  bhk_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && !busy),
    .req_i       (in_req_i),
    .keep_i      (keep_q),
    .busy_o      (busy),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign in_stall_o = busy;
  assign res_ready  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q      <= KEEP_W'(KEEP_RESET);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
      if (res.valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_req_q <= res.req;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule
